@@ hdl/pes_pkg.sv @@
// ============================================================================
// pes_pkg
// Shared constants and types for the product-except-self core.
// ============================================================================
package pes_pkg;

    localparam int MAX_LEN = 64;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_BACK,
        S_EMIT_RD,
        S_EMIT_LD
    } pes_state_t;

endpackage

@@ hdl/product_except_self_prefix_suffix_core.sv @@
// ============================================================================
// product_except_self_prefix_suffix_core
// Product of all other elements of a vector, by prefix and suffix products.
// ============================================================================
// Elements stream in one word per cycle while the core stores each element
// and its exclusive prefix product in two simple dual-port memories (one read,
// one write per cycle, registered read). The word marked is_last
// starts a backward pass that reads one entry per cycle and folds in the
// suffix product. Results then leave in index order, each word passing a
// memory read and then the output register, and wait while the result side
// stalls. The input side stalls from the last word until the final result
// sits in the output register; the next vector may load while that result
// waits. Up to MAX_LEN elements are kept; later ones are dropped and every
// result of that vector carries overflow. All products wrap modulo 2^32,
// and a one-element vector yields 1.
// ============================================================================
module product_except_self_prefix_suffix_core
    import pes_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     is_last,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] product,
    output logic                     last_result,
    output logic                     overflow
);

    logic [DATA_W-1:0] elem_mem [MAX_LEN];
    logic [DATA_W-1:0] part_mem [MAX_LEN];

    pes_state_t        state_reg, state_next;
    logic [DATA_W-1:0] running_reg, running_next;
    logic [DATA_W-1:0] suffix_reg, suffix_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  last_idx_reg, last_idx_next;
    logic              issue_done_reg, issue_done_next;
    logic              bk_valid_reg, bk_valid_next;
    logic [IDX_W-1:0]  bk_addr_reg, bk_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_product_reg, out_product_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    logic [DATA_W-1:0] elem_rd_reg;
    logic [DATA_W-1:0] part_rd_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              elem_we;
    logic              part_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] part_wdata;

    logic              in_acc;
    logic              out_acc;
    logic              has_room;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] mul_res;
    logic [DATA_W-1:0] part_mul;

    assign item_stall   = (state_reg != S_LOAD);
    assign in_acc       = item_valid && !item_stall;
    assign out_acc      = out_valid_reg && !result_stall;
    assign has_room     = (count_reg < CNT_W'(MAX_LEN));

    assign mul_a    = (state_reg == S_LOAD) ? running_reg : suffix_reg;
    assign mul_b    = (state_reg == S_LOAD) ? DATA_W'(value) : elem_rd_reg;
    assign mul_res  = mul_a * mul_b;
    assign part_mul = part_rd_reg * suffix_reg;

    assign result_valid = out_valid_reg;
    assign product      = out_product_reg;
    assign last_result  = out_last_reg;
    assign overflow     = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[wr_addr] <= DATA_W'(value);
        end
        if (part_we)
        begin
            part_mem[wr_addr] <= part_wdata;
        end
        if (rd_en)
        begin
            elem_rd_reg <= elem_mem[rd_addr];
            part_rd_reg <= part_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            running_reg    <= DATA_W'(1);
            suffix_reg     <= DATA_W'(1);
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            idx_reg        <= '0;
            last_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            bk_valid_reg   <= 1'b0;
            bk_addr_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            suffix_reg     <= suffix_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            idx_reg        <= idx_next;
            last_idx_reg   <= last_idx_next;
            issue_done_reg <= issue_done_next;
            bk_valid_reg   <= bk_valid_next;
            bk_addr_reg    <= bk_addr_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_product_reg <= out_product_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        running_next     = running_reg;
        suffix_next      = suffix_reg;
        count_next       = count_reg;
        dropped_next     = dropped_reg;
        idx_next         = idx_reg;
        last_idx_next    = last_idx_reg;
        issue_done_next  = issue_done_reg;
        bk_valid_next    = 1'b0;
        bk_addr_next     = bk_addr_reg;
        out_valid_next   = out_valid_reg && !out_acc;
        out_product_next = out_product_reg;
        out_last_next    = out_last_reg;
        out_ovf_next     = out_ovf_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;
        elem_we          = 1'b0;
        part_we          = 1'b0;
        wr_addr          = count_reg[IDX_W-1:0];
        part_wdata       = running_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (has_room)
                    begin
                        elem_we      = 1'b1;
                        part_we      = 1'b1;
                        running_next = mul_res;
                        count_next   = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        // last index to hold: the new word if stored, else the top one
                        last_idx_next   = has_room ? count_reg[IDX_W-1:0]
                                                   : IDX_W'(MAX_LEN - 1);
                        idx_next        = last_idx_next;
                        issue_done_next = 1'b0;
                        suffix_next     = DATA_W'(1);
                        state_next      = S_BACK;
                    end
                end
            end

            S_BACK:
            begin
                // issue one read per cycle, walking down
                if (!issue_done_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_reg;
                    bk_valid_next = 1'b1;
                    bk_addr_next  = idx_reg;
                    if (idx_reg == '0)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                // fold suffix into the entry read last cycle
                if (bk_valid_reg)
                begin
                    part_we     = 1'b1;
                    wr_addr     = bk_addr_reg;
                    part_wdata  = part_mul;
                    suffix_next = mul_res;
                    if (bk_addr_reg == '0)
                    begin
                        idx_next   = '0;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_EMIT_RD:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg;
                    state_next = S_EMIT_LD;
                end
            end

            S_EMIT_LD:
            begin
                out_valid_next   = 1'b1;
                out_product_next = part_rd_reg;
                out_last_next    = (idx_reg == last_idx_reg);
                out_ovf_next     = dropped_reg;
                if (idx_reg == last_idx_reg)
                begin
                    running_next = DATA_W'(1);
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("element count beyond capacity");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> (count_reg == CNT_W'(MAX_LEN)))
        else $error("drop flagged with free capacity");

    a_last_starts_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_last) |=> (state_reg == S_BACK))
        else $error("last word did not start backward pass");

    a_out_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD) |-> !out_valid_reg)
        else $error("output register overwritten");

    a_back_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BACK) && bk_valid_reg) |-> (bk_addr_reg <= last_idx_reg))
        else $error("backward pass address out of range");
`endif

endmodule
